FILE: hw/rtl/rld_pkg.sv
package rld_pkg;

  // field widths
  localparam int unsigned ByteW   = 8;
  localparam int unsigned LenW    = 16;
  localparam int unsigned RecNumW = 16;
  localparam int unsigned HdrPosW = 3;

  // header layout
  localparam logic [HdrPosW-1:0] HdrBytes = 3'd5;
  localparam logic [HdrPosW-1:0] LenHiPos = 3'd3;
  localparam logic [HdrPosW-1:0] LenLoPos = 3'd4;

  // one input byte of the buffer
  typedef struct packed {
    logic [ByteW-1:0] data_byte;
    logic             end_of_buffer;
  } in_t;

  // one tagged output byte
  typedef struct packed {
    logic [ByteW-1:0]   byte_out;
    logic [RecNumW-1:0] record_number;
    logic               in_header;
    logic               record_done;
    logic               truncated;
  } out_t;

  // framing state carried from byte to byte
  typedef struct packed {
    logic [HdrPosW-1:0] header_position;
    logic [ByteW-1:0]   length_high_byte;
    logic [LenW-1:0]    payload_left;
    logic [RecNumW-1:0] record_count;
  } state_t;

endpackage

FILE: hw/rtl/rld_step.sv
module rld_step (
  input  rld_pkg::state_t state_i,
  input  rld_pkg::in_t    item_i,
  output rld_pkg::state_t state_o,
  output rld_pkg::out_t   result_o
);

  logic                        is_hdr;
  logic                        done;
  logic [rld_pkg::LenW-1:0]    len_word;
  logic [rld_pkg::LenW-1:0]    pl_dec;
  rld_pkg::state_t             nxt;

  assign is_hdr   = state_i.header_position < rld_pkg::HdrBytes;
  assign len_word = {state_i.length_high_byte, item_i.data_byte};
  assign pl_dec   = state_i.payload_left -
                    rld_pkg::LenW'(state_i.payload_left != '0);

  // header or payload update for this byte
  always_comb begin
    nxt  = state_i;
    done = 1'b0;
    if (is_hdr) begin
      if (state_i.header_position == rld_pkg::LenHiPos) begin
        nxt.length_high_byte = item_i.data_byte;
      end
      if (state_i.header_position == rld_pkg::LenLoPos) begin
        nxt.payload_left = len_word;
        done             = (len_word == '0);
      end
      nxt.header_position = rld_pkg::HdrPosW'(state_i.header_position + 1'b1);
    end else begin
      nxt.payload_left = pl_dec;
      done             = (pl_dec == '0);
    end
    // record complete: clear framing, bump the record count
    if (done) begin
      nxt.header_position  = '0;
      nxt.length_high_byte = '0;
      nxt.payload_left     = '0;
      nxt.record_count     = rld_pkg::RecNumW'(state_i.record_count + 1'b1);
    end
    // end of buffer: back to reset values
    if (item_i.end_of_buffer) begin
      nxt = '0;
    end
  end

  assign state_o = nxt;

  // tagged result
  always_comb begin
    result_o.byte_out      = item_i.data_byte;
    result_o.record_number = state_i.record_count;
    result_o.in_header     = is_hdr;
    result_o.record_done   = done;
    result_o.truncated     = item_i.end_of_buffer & ~done;
  end

endmodule

FILE: hw/rtl/record_length_deframer_core.sv
// a result is registered and appears in the cycle after its byte transfer
// throughput: one byte per cycle while the sink takes each result; framing state is updated
// in the same cycle the byte is taken, and the result register frees as the sink takes it
// reset: rst_ni clears the framing state and the result valid flag
module record_length_deframer_core (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  rld_pkg::in_t    in_data_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output rld_pkg::out_t   out_data_o
);

  rld_pkg::state_t state_q, state_d;
  rld_pkg::out_t   result_d, result_q;
  logic            out_valid_q, out_valid_d;
  logic            in_xfer;

  // take a byte whenever the result register is empty or draining
  assign in_ready_o = ~out_valid_q | out_ready_i;
  assign in_xfer    = in_valid_i & in_ready_o;

  rld_step u_step (
    .state_i  (state_q),
    .item_i   (in_data_i),
    .state_o  (state_d),
    .result_o (result_d)
  );

  // result valid flag
  always_comb begin
    out_valid_d = out_valid_q;
    if (in_xfer) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (in_xfer) begin
        state_q <= state_d;
      end
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      result_q <= result_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = result_q;

  // header position never runs past the payload phase
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.header_position <= rld_pkg::HdrBytes)
    else $error("header position out of range");

  // end of buffer returns the framing state to reset values
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && in_data_i.end_of_buffer) |=>
      (state_q.record_count == '0 && state_q.header_position == '0 &&
       state_q.payload_left == '0))
    else $error("state not cleared after end of buffer");

  // a completed record starts the next header
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && result_d.record_done) |=>
      (state_q.header_position == '0 && out_data_o.record_done))
    else $error("record completion did not restart header");

  // a truncated byte never also completes its record
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.truncated) |-> !out_data_o.record_done)
    else $error("truncated and done both set");

endmodule

FILE: dv/tb_record_length_deframer_core.sv
module tb_record_length_deframer_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned QuietLimit     = 2000;
  localparam int unsigned HoldCycles     = 300;
  localparam int unsigned RandomTarget   = 1500;
  localparam int unsigned ZeroRunRecords = 8;
  localparam int unsigned MaxReported    = 10;

  logic          clk_i;
  logic          rst_ni;
  logic          in_valid;
  logic          in_ready_o;
  rld_pkg::in_t  in_data;
  logic          out_valid_o;
  logic          out_ready;
  rld_pkg::out_t out_data_o;

  // expected tagged bytes, oldest first
  rld_pkg::out_t tagged_byte_q[$];
  // bytes of the buffer being built
  logic [rld_pkg::ByteW-1:0] buf_q[$];

  // framing state of the predictor
  logic [rld_pkg::HdrPosW-1:0] hdr_pos;
  logic [rld_pkg::ByteW-1:0]   len_hi;
  logic [rld_pkg::LenW-1:0]    pay_left;
  logic [rld_pkg::RecNumW-1:0] rec_count;

  int unsigned mismatch_cnt;
  int unsigned quiet_cycles;
  int unsigned bytes_sent;
  logic        idle_en;
  logic        hold_req;

  record_length_deframer_core u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready),
    .out_data_o (out_data_o)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // gap length: mostly none, some short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // tag one byte and advance the framing state
  function automatic rld_pkg::out_t tag_byte(input rld_pkg::in_t item);
    rld_pkg::out_t res;
    logic done;
    res.byte_out      = item.data_byte;
    res.record_number = rec_count;
    done = 1'b0;
    if (hdr_pos < rld_pkg::HdrBytes) begin
      res.in_header = 1'b1;
      if (hdr_pos == rld_pkg::LenHiPos) begin
        len_hi = item.data_byte;
      end else if (hdr_pos == rld_pkg::LenLoPos) begin
        pay_left = {len_hi, item.data_byte};
      end
      hdr_pos = hdr_pos + 1'b1;
      if (hdr_pos == rld_pkg::HdrBytes && pay_left == '0) done = 1'b1;
    end else begin
      res.in_header = 1'b0;
      if (pay_left != '0) pay_left = pay_left - 1'b1;
      if (pay_left == '0) done = 1'b1;
    end
    if (done) begin
      hdr_pos   = '0;
      len_hi    = '0;
      pay_left  = '0;
      rec_count = rec_count + 1'b1;
    end
    res.record_done = done;
    res.truncated   = item.end_of_buffer && !done;
    // end of buffer drops whatever is open
    if (item.end_of_buffer) begin
      hdr_pos   = '0;
      len_hi    = '0;
      pay_left  = '0;
      rec_count = '0;
    end
    return res;
  endfunction

  // check results first, then predict, so a same-edge byte is never matched
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready) begin
        if (tagged_byte_q.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= MaxReported)
            $display("%0t: result with nothing expected: %p", $realtime, out_data_o);
        end else begin
          rld_pkg::out_t exp_t;
          exp_t = tagged_byte_q.pop_front();
          if (out_data_o.byte_out !== exp_t.byte_out ||
              out_data_o.record_number !== exp_t.record_number ||
              out_data_o.in_header !== exp_t.in_header ||
              out_data_o.record_done !== exp_t.record_done ||
              out_data_o.truncated !== exp_t.truncated) begin
            mismatch_cnt++;
            if (mismatch_cnt <= MaxReported)
              $display("%0t: mismatch expected %p actual %p", $realtime, exp_t, out_data_o);
          end
        end
      end
      if (in_valid && in_ready_o)
        tagged_byte_q.insert(tagged_byte_q.size(), tag_byte(in_data));
      // watchdog on cycles with no transfer
      if ((in_valid && in_ready_o) || (out_valid_o && out_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= QuietLimit) begin
          $display("watchdog: no transfer for %0d cycles", quiet_cycles);
          $display("Test completed with failures");
          $finish;
        end
      end
    end
  end

  // result sink: random stalls, plus one long hold-off on request
  initial begin
    int stall_left;
    int hold_left;
    stall_left = 0;
    hold_left  = 0;
    out_ready  = 1'b0;
    forever begin
      @(posedge clk_i);
      if (!rst_ni) begin
        out_ready <= 1'b0;
      end else if (hold_req) begin
        hold_left = HoldCycles - 1;
        hold_req  <= 1'b0;
        out_ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (!idle_en) begin
        out_ready <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        stall_left = pick_gap();
        out_ready <= (stall_left == 0);
        if (stall_left > 0) stall_left--;
      end
    end
  end

  // offer one byte, wait for its transfer
  task automatic send_byte(input logic [rld_pkg::ByteW-1:0] b, input logic eob);
    int gap;
    gap = idle_en ? pick_gap() : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data.data_byte     <= b;
    in_data.end_of_buffer <= eob;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    bytes_sent++;
  endtask

  // append a record header and payload, cut after limit bytes
  task automatic add_record(input int len, input int limit);
    logic [rld_pkg::LenW-1:0] len16;
    int total;
    len16 = rld_pkg::LenW'(len);
    total = rld_pkg::HdrBytes + len;
    if (total > limit) total = limit;
    for (int k = 0; k < total; k++) begin
      if (k == rld_pkg::LenHiPos) buf_q.insert(buf_q.size(), len16[15:8]);
      else if (k == rld_pkg::LenLoPos) buf_q.insert(buf_q.size(), len16[7:0]);
      else buf_q.insert(buf_q.size(), rld_pkg::ByteW'($urandom_range(0, 255)));
    end
  endtask

  // send the built buffer, end of buffer on its last byte
  task automatic send_buffer();
    for (int k = 0; k < buf_q.size(); k++) send_byte(buf_q[k], k == buf_q.size() - 1);
    buf_q.delete();
  endtask

  function automatic int pick_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return 0;
    if (r < 97) return $urandom_range(1, 24);
    return $urandom_range(256, 300);
  endfunction

  // lone byte, zero-length record, boundary end, truncation in header and payload
  task automatic test_directed();
    // a lone byte is a truncated header byte
    send_byte(8'hA5, 1'b1);
    // zero-length record then one-byte record, ends on the boundary
    buf_q = '{8'h00, 8'hFF, 8'h00, 8'h00, 8'h00,
              8'hFF, 8'h00, 8'hFF, 8'h00, 8'h01, 8'h5A};
    send_buffer();
    // ends inside the header
    buf_q = '{8'h17, 8'h03, 8'h03, 8'h12};
    send_buffer();
    // largest length, ends inside the payload
    buf_q = '{8'h17, 8'h03, 8'h03, 8'hFF, 8'hFF, 8'h00, 8'hFF};
    send_buffer();
  endtask

  // well-formed buffers with random content, some truncated, some noise
  task automatic test_random_buffers();
    int kind;
    int nrec;
    while (bytes_sent < RandomTarget) begin
      if ($urandom_range(0, 7) == 0) idle_en = ~idle_en;
      kind = $urandom_range(0, 99);
      nrec = $urandom_range(1, 4);
      if (kind < 15) begin
        repeat ($urandom_range(1, 12))
          buf_q.insert(buf_q.size(), rld_pkg::ByteW'($urandom_range(0, 255)));
      end else begin
        repeat (nrec) add_record(pick_length(), 1 << 20);
        if (kind >= 80) add_record($urandom_range(0, 65535), $urandom_range(1, 12));
      end
      send_buffer();
    end
    idle_en = 1'b1;
  endtask

  // sink holds off while the source keeps offering bytes
  task automatic test_backpressure();
    hold_req <= 1'b1;
    idle_en  = 1'b0;
    add_record(20, 1 << 20);
    add_record(30, 1 << 20);
    send_buffer();
    idle_en = 1'b1;
  endtask

  // a run of zero-length records back to back in one buffer
  task automatic test_zero_length_run();
    idle_en = 1'b0;
    for (int r = 0; r < ZeroRunRecords; r++) begin
      for (int j = 0; j < rld_pkg::HdrBytes; j++) begin
        send_byte((j < rld_pkg::LenHiPos) ? rld_pkg::ByteW'($urandom_range(0, 255)) : 8'h00,
                  (r == ZeroRunRecords - 1) && (j == rld_pkg::HdrBytes - 1));
      end
    end
    idle_en = 1'b1;
  endtask

  // reset, tests in turn, drain, verdict
  initial begin
    rst_ni       = 1'b0;
    in_valid     = 1'b0;
    in_data      = '0;
    idle_en      = 1'b1;
    hold_req     = 1'b0;
    hdr_pos      = '0;
    len_hi       = '0;
    pay_left     = '0;
    rec_count    = '0;
    mismatch_cnt = 0;
    quiet_cycles = 0;
    bytes_sent   = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_random_buffers();
    test_backpressure();
    test_zero_length_run();

    in_valid <= 1'b0;
    while (tagged_byte_q.size() != 0) @(posedge clk_i);
    repeat (5) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
